// ===== rtl/grain_resampling_reader_defines.svh =====
// ---------------------------------------------------------------------------
// grain_resampling_reader_defines.svh
// concurrent check macros shared by the grain reader rtl
// ---------------------------------------------------------------------------
`ifndef GRAIN_RESAMPLING_READER_DEFINES_SVH
`define GRAIN_RESAMPLING_READER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GRR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grain reader check failed");

// next-cycle implication, disabled during reset
`define GRR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grain reader check failed");

`endif

// ===== rtl/grr_pkg.sv =====
// ---------------------------------------------------------------------------
// grr_pkg
// widths, codes, types and helpers shared by the grain reader
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package grr_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int ADDR_BITS     = 16;
   localparam int FRAC_BITS     = 28;
   localparam int FI_BITS       = 16;
   localparam int POS_BITS      = ADDR_BITS + FRAC_BITS;
   localparam int RATE_BITS     = FRAC_BITS + 4;
   localparam int LEN_BITS      = 20;
   localparam int PAN_BITS      = 17;
   localparam int MODE_BITS     = 2;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   // interpolation working width, headroom for the doubled coefficients
   localparam int T_BITS        = SAMPLE_BITS + 6;
   localparam int PROD_BITS     = T_BITS + PAN_BITS + 1;

   localparam logic [MODE_BITS-1:0] MODE_WRITE = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TICK  = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_START = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_START_POS = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LENGTH    = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_DELAY     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RATE      = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SLOPE     = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PAN       = 3'd5;

   localparam logic [PAN_BITS-1:0]  PAN_ONE    = PAN_BITS'(1 << FI_BITS);
   localparam logic [PAN_BITS-1:0]  PAN_RESET  = PAN_BITS'(1 << (FI_BITS - 1));
   localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(1) << FRAC_BITS;

   localparam logic signed [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1 << (FI_BITS - 1));
   localparam logic signed [T_BITS-1:0] SMAX_T = T_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam logic signed [T_BITS-1:0] SMIN_T = -SMAX_T - T_BITS'(1);

   // one multiply-round-add step of the shared arithmetic unit
   typedef struct packed {
      logic signed [T_BITS-1:0] operand;
      logic [PAN_BITS-1:0]      gain;
      logic signed [T_BITS-1:0] addend;
   } mac_op_type;

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [T_BITS-1:0] v);
      logic signed [SAMPLE_BITS-1:0] r;
      if (v > SMAX_T) begin
         r = SMAX_T[SAMPLE_BITS-1:0];
      end else if (v < SMIN_T) begin
         r = SMIN_T[SAMPLE_BITS-1:0];
      end else begin
         r = v[SAMPLE_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/grr_req_if.sv =====
// ---------------------------------------------------------------------------
// grr_req_if
// request channel: store writes, ticks and grain starts
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface grr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [grr_pkg::MODE_BITS-1:0]         mode;
   logic [grr_pkg::ADDR_BITS-1:0]         address;
   logic signed [grr_pkg::SAMPLE_BITS-1:0] sample_in;

   modport source (output valid, mode, address, sample_in, input ready);
   modport sink   (input valid, mode, address, sample_in, output ready);
endinterface

// ===== rtl/grr_rsp_if.sv =====
// ---------------------------------------------------------------------------
// grr_rsp_if
// response channel: one panned frame per tick
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface grr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [grr_pkg::SAMPLE_BITS-1:0] first_channel;
   logic signed [grr_pkg::SAMPLE_BITS-1:0] second_channel;
   logic                                  sounding;
   logic                                  finished;

   modport source (output valid, first_channel, second_channel, sounding, finished,
                   input ready);
   modport sink   (input valid, first_channel, second_channel, sounding, finished,
                   output ready);
endinterface

// ===== rtl/grr_mac.sv =====
// ---------------------------------------------------------------------------
// grr_mac
// shared multiply, round-half-up by 2^16 and add, used for horner and pan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grr_mac (
   input  grr_pkg::mac_op_type                op,
   output logic signed [grr_pkg::T_BITS-1:0]  result
);

   logic signed [grr_pkg::PROD_BITS-1:0] prod;
   logic signed [grr_pkg::PROD_BITS-1:0] rnd_sum;
   logic signed [grr_pkg::PROD_BITS-1:0] shifted;

   assign prod    = grr_pkg::PROD_BITS'(op.operand)
                  * grr_pkg::PROD_BITS'($signed({1'b0, op.gain}));
   assign rnd_sum = prod + grr_pkg::RND_HALF;
   assign shifted = rnd_sum >>> grr_pkg::FI_BITS;
   assign result  = shifted[grr_pkg::T_BITS-1:0] + op.addend;

endmodule

// ===== rtl/grain_resampling_reader.sv =====
// ---------------------------------------------------------------------------
// grain_resampling_reader
// one audio grain reading a circular sample store with cubic interpolation
// ---------------------------------------------------------------------------
// The block works on one word at a time. A store write or a grain start is
// taken while idle. A tick that gives silence or the finished frame goes through
// the emit state into the output register once that register is free. A sounding
// tick runs four reads of the single-port sample memory (one read a cycle, with
// registered read data), a coefficient step, three horner steps, a halving step
// and two pan steps, horner and pan through one shared multiplier, then the output load.
// The sample store has no reset; only entries that were written may be read.
// The next word is taken as soon as the block is back in idle, even while
// the previous result still waits in the output register.
`timescale 1ns / 1ps
`include "grain_resampling_reader_defines.svh"

module grain_resampling_reader (
   input  logic                                   clock,
   input  logic                                   reset,
   grr_req_if.sink                                req_bus,
   grr_rsp_if.source                              rsp_bus,
   input  logic                                   csr_we,
   input  logic [grr_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [grr_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_COEF  = 3'd2;
   localparam logic [2:0] ST_HORN  = 3'd3;
   localparam logic [2:0] ST_HALF  = 3'd4;
   localparam logic [2:0] ST_PAN_A = 3'd5;
   localparam logic [2:0] ST_PAN_B = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   localparam int SB = grr_pkg::SAMPLE_BITS;
   localparam int TB = grr_pkg::T_BITS;

   // configuration registers
   logic [grr_pkg::ADDR_BITS-1:0]  cfg_start_ff;
   logic [grr_pkg::LEN_BITS-1:0]   cfg_length_ff;
   logic [grr_pkg::LEN_BITS-1:0]   cfg_delay_ff;
   logic [grr_pkg::RATE_BITS-1:0]  cfg_rate_ff;
   logic signed [grr_pkg::RATE_BITS-1:0] cfg_slope_ff;
   logic [grr_pkg::PAN_BITS-1:0]   cfg_pan_ff;

   // grain state
   logic [2:0]                     state_ff, state_in;
   logic [2:0]                     cnt_ff, cnt_in;
   logic                           running_ff, running_in;
   logic [grr_pkg::POS_BITS-1:0]   pos_ff, pos_in;
   logic [grr_pkg::RATE_BITS-1:0]  rate_ff, rate_in;
   logic [grr_pkg::LEN_BITS-1:0]   delay_ff, delay_in;
   logic [grr_pkg::LEN_BITS-1:0]   done_ff, done_in;
   logic [grr_pkg::LEN_BITS-1:0]   len_ff, len_in;
   logic signed [grr_pkg::RATE_BITS-1:0] slope_ff, slope_in;
   logic [grr_pkg::PAN_BITS-1:0]   pan_ff, pan_in;

   // datapath
   logic signed [SB-1:0]           y_ff [4];
   logic signed [TB-1:0]           t_ff, t_in;
   logic signed [TB-1:0]           c1_ff, c2_ff, y1x2_ff;
   logic [grr_pkg::FI_BITS-1:0]    frac_ff;
   logic signed [SB-1:0]           res_first_ff, res_second_ff;
   logic                           res_snd_ff, res_fin_ff;

   // output register
   logic                           rsp_valid_ff;
   logic signed [SB-1:0]           rsp_first_ff, rsp_second_ff;
   logic                           rsp_snd_ff, rsp_fin_ff;

   // sample memory
   logic [SB-1:0]                  store_mem [1 << grr_pkg::ADDR_BITS];
   logic [SB-1:0]                  rd_data_ff;
   logic                           mem_we;
   logic [grr_pkg::ADDR_BITS-1:0]  mem_addr;

   logic                           req_fire;
   logic                           emit_go;
   logic                           rd_issue;
   grr_pkg::mac_op_type            mac_op;
   logic signed [TB-1:0]           mac_res;
   logic signed [TB-1:0]           y0e, y1e, y2e, y3e, d12, c1_w, c3_w, c2_w;
   logic signed [grr_pkg::RATE_BITS+1:0] rate_sum;
   logic [grr_pkg::RATE_BITS-1:0]  rate_next;

   assign req_fire      = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign emit_go       = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.first_channel  = rsp_first_ff;
   assign rsp_bus.second_channel = rsp_second_ff;
   assign rsp_bus.sounding       = rsp_snd_ff;
   assign rsp_bus.finished       = rsp_fin_ff;

   // ---- configuration ----
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_start_ff  <= '0;
         cfg_length_ff <= '0;
         cfg_delay_ff  <= '0;
         cfg_rate_ff   <= grr_pkg::RATE_RESET;
         cfg_slope_ff  <= '0;
         cfg_pan_ff    <= grr_pkg::PAN_RESET;
      end else if (csr_we) begin
         case (csr_index)
            grr_pkg::CSR_START_POS: cfg_start_ff  <= csr_wdata[grr_pkg::ADDR_BITS-1:0];
            grr_pkg::CSR_LENGTH:    cfg_length_ff <= csr_wdata[grr_pkg::LEN_BITS-1:0];
            grr_pkg::CSR_DELAY:     cfg_delay_ff  <= csr_wdata[grr_pkg::LEN_BITS-1:0];
            grr_pkg::CSR_RATE:      cfg_rate_ff   <= csr_wdata[grr_pkg::RATE_BITS-1:0];
            grr_pkg::CSR_SLOPE:     cfg_slope_ff  <= $signed(csr_wdata[grr_pkg::RATE_BITS-1:0]);
            grr_pkg::CSR_PAN:       cfg_pan_ff    <= csr_wdata[grr_pkg::PAN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // ---- sample memory, single port ----
   assign mem_we   = req_fire && (req_bus.mode == grr_pkg::MODE_WRITE);
   assign rd_issue = (state_ff == ST_READ) && (cnt_ff < 3'd4);
   // neighbours idx-1 .. idx+2, wrapping round the store
   assign mem_addr = mem_we ? req_bus.address
                   : pos_ff[grr_pkg::POS_BITS-1:grr_pkg::FRAC_BITS]
                     + grr_pkg::ADDR_BITS'(cnt_ff) - grr_pkg::ADDR_BITS'(1);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= req_bus.sample_in;
      end else if (rd_issue) begin
         rd_data_ff <= store_mem[mem_addr];
      end
   end

   // ---- coefficients, all doubled ----
   assign y0e  = TB'(y_ff[0]);
   assign y1e  = TB'(y_ff[1]);
   assign y2e  = TB'(y_ff[2]);
   assign y3e  = TB'(y_ff[3]);
   assign d12  = y1e - y2e;
   assign c1_w = y2e - y0e;
   assign c3_w = (d12 <<< 1) + d12 + (y3e - y0e);
   assign c2_w = ((y0e - y1e) <<< 1) + c1_w - c3_w;

   // ---- rate ramp, clamped to the unsigned range ----
   assign rate_sum = $signed({2'b00, rate_ff}) + (grr_pkg::RATE_BITS+2)'(slope_ff);
   always_comb begin
      if (rate_sum[grr_pkg::RATE_BITS+1]) begin
         rate_next = '0;
      end else if (rate_sum[grr_pkg::RATE_BITS]) begin
         rate_next = '1;
      end else begin
         rate_next = rate_sum[grr_pkg::RATE_BITS-1:0];
      end
   end

   // ---- shared multiplier ----
   always_comb begin
      mac_op.operand = t_ff;
      mac_op.gain    = {1'b0, frac_ff};
      mac_op.addend  = y1x2_ff;
      case (state_ff)
         ST_HORN: begin
            if (cnt_ff == 3'd0) begin
               mac_op.addend = c2_ff;
            end else if (cnt_ff == 3'd1) begin
               mac_op.addend = c1_ff;
            end else begin
               mac_op.addend = y1x2_ff;
            end
         end
         ST_PAN_A: begin
            mac_op.gain   = grr_pkg::PAN_ONE - pan_ff;
            mac_op.addend = '0;
         end
         ST_PAN_B: begin
            mac_op.gain   = pan_ff;
            mac_op.addend = '0;
         end
         default: begin
         end
      endcase
   end

   grr_mac u_mac (
      .op     (mac_op),
      .result (mac_res)
   );

   // ---- sequencer ----
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      running_in = running_ff;
      pos_in     = pos_ff;
      rate_in    = rate_ff;
      delay_in   = delay_ff;
      done_in    = done_ff;
      len_in     = len_ff;
      slope_in   = slope_ff;
      pan_in     = pan_ff;
      t_in       = t_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_bus.mode == grr_pkg::MODE_START) begin
               pos_in     = {cfg_start_ff, {grr_pkg::FRAC_BITS{1'b0}}};
               rate_in    = cfg_rate_ff;
               delay_in   = cfg_delay_ff;
               done_in    = '0;
               len_in     = cfg_length_ff;
               slope_in   = cfg_slope_ff;
               pan_in     = (cfg_pan_ff > grr_pkg::PAN_ONE) ? grr_pkg::PAN_ONE : cfg_pan_ff;
               running_in = 1'b1;
            end else if (req_fire && req_bus.mode == grr_pkg::MODE_TICK) begin
               if (!running_ff) begin
                  state_in = ST_EMIT;
               end else if (delay_ff != '0) begin
                  delay_in = delay_ff - grr_pkg::LEN_BITS'(1);
                  state_in = ST_EMIT;
               end else if (done_ff >= len_ff) begin
                  running_in = 1'b0;
                  state_in   = ST_EMIT;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd4) begin
               state_in = ST_COEF;
            end
         end
         ST_COEF: begin
            t_in     = c3_w;
            cnt_in   = '0;
            pos_in   = pos_ff + grr_pkg::POS_BITS'(rate_ff);
            rate_in  = rate_next;
            done_in  = done_ff + grr_pkg::LEN_BITS'(1);
            state_in = ST_HORN;
         end
         ST_HORN: begin
            t_in   = mac_res;
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff == 3'd2) begin
               state_in = ST_HALF;
            end
         end
         ST_HALF: begin
            t_in     = (t_ff + TB'(1)) >>> 1;
            state_in = ST_PAN_A;
         end
         ST_PAN_A: state_in = ST_PAN_B;
         ST_PAN_B: state_in = ST_EMIT;
         ST_EMIT: begin
            if (emit_go) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         cnt_ff     <= '0;
         running_ff <= 1'b0;
         pos_ff     <= '0;
         rate_ff    <= '0;
         delay_ff   <= '0;
         done_ff    <= '0;
         len_ff     <= '0;
         slope_ff   <= '0;
         pan_ff     <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         running_ff <= running_in;
         pos_ff     <= pos_in;
         rate_ff    <= rate_in;
         delay_ff   <= delay_in;
         done_ff    <= done_in;
         len_ff     <= len_in;
         slope_ff   <= slope_in;
         pan_ff     <= pan_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      t_ff <= t_in;
      if (state_ff == ST_READ && cnt_ff != 3'd0) begin
         y_ff[0] <= y_ff[1];
         y_ff[1] <= y_ff[2];
         y_ff[2] <= y_ff[3];
         y_ff[3] <= $signed(rd_data_ff);
      end
      if (state_ff == ST_COEF) begin
         c1_ff   <= c1_w;
         c2_ff   <= c2_w;
         y1x2_ff <= y1e <<< 1;
         frac_ff <= pos_ff[grr_pkg::FRAC_BITS-1 -: grr_pkg::FI_BITS];
      end
      if (state_ff == ST_IDLE) begin
         // silence or finished word unless a sounding tick overwrites it
         res_first_ff  <= '0;
         res_second_ff <= '0;
         res_snd_ff    <= 1'b0;
         res_fin_ff    <= running_ff && (delay_ff == '0) && (done_ff >= len_ff);
      end
      if (state_ff == ST_PAN_A) begin
         res_first_ff <= grr_pkg::sat_sample(mac_res);
      end
      if (state_ff == ST_PAN_B) begin
         res_second_ff <= grr_pkg::sat_sample(mac_res);
         res_snd_ff    <= 1'b1;
         res_fin_ff    <= 1'b0;
      end
   end

   // ---- output register ----
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_first_ff  <= res_first_ff;
         rsp_second_ff <= res_second_ff;
         rsp_snd_ff    <= res_snd_ff;
         rsp_fin_ff    <= res_fin_ff;
      end
   end

   // ---- checks ----
   `GRR_ASSERT_NEXT(a_tick_leaves_idle, clock, reset, req_fire && req_bus.mode == grr_pkg::MODE_TICK, state_ff != ST_IDLE)
   `GRR_ASSERT_NOW(a_silent_is_zero, clock, reset, rsp_valid_ff && !rsp_snd_ff, rsp_first_ff == '0 && rsp_second_ff == '0)
   `GRR_ASSERT_NOW(a_finish_stops_grain, clock, reset, emit_go && res_fin_ff, !running_ff && !res_snd_ff)

endmodule
